// ===== hdl/bdq_pkg.sv =====
// Package: sizes, request and status codes, and index helpers for the deque unit.
`timescale 1ns / 1ps

package bdq_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // Port field widths
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POP_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // Physical slot of logical offset off from base, circular over DEPTH
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return IDX_W'(s);
  endfunction

  // One slot towards the front, circular
  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] r;
    if (base == '0) r = IDX_W'(DEPTH - 1);
    else            r = base - IDX_W'(1);
    return r;
  endfunction

endpackage

// ===== hdl/bdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module bdq_ram #(
  parameter int unsigned WORDS = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bounded_deque_with_value_removal_unit.sv =====
// Top level: bounded deque with removal by value, entries held in one synchronous RAM.
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------------------------
//  request   in         in_valid_i / in_stall_o  action_i[2:0], value_i[31:0]
//  result    out        out_valid_o/out_stall_i  popped_word_o, status_o, count_after_o,
//                                                removed_count_o
//
//  Per transaction: push, remove on an empty store and every rejected or no-op request load
//  the result on accept; pop waits for the registered RAM read; remove reads each held entry
//  in turn, then makes the last compare and loads the result, all set by the single read port of the entry RAM.
//  Reset (rst_ni low, asynchronous) empties the deque; RAM contents are left as they are,
//  only written slots are ever read, so no clearing pass is needed.
//  One request is in flight at a time; a request enters at the earliest in the cycle its
//  predecessor's result leaves the result register, so a stalled result holds off requests.
//
module bounded_deque_with_value_removal_unit
  import bdq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [VAL_W-1:0]     value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [POP_W-1:0]     popped_word_o,
  output logic [ST_W-1:0]      status_o,
  output logic [CNT_OUT_W-1:0] count_after_o,
  output logic [CNT_OUT_W-1:0] removed_count_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request
  localparam logic [1:0] S_POP  = 2'd1;  // popped word arriving from RAM
  localparam logic [1:0] S_RM   = 2'd2;  // compaction walk

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] rd_k_q, rd_k_d;   // next logical offset to read
  logic [CNT_W-1:0] wr_n_q, wr_n_d;   // entries kept so far
  logic             pend_q, pend_d;   // RAM read data valid this cycle

  // Result register
  logic                 out_valid_q;
  logic [POP_W-1:0]     popped_q;
  logic [ST_W-1:0]      status_q;
  logic [CNT_OUT_W-1:0] count_after_q;
  logic [CNT_OUT_W-1:0] removed_q;

  logic              out_load;
  logic [DATA_W-1:0] ld_popped;
  status_e           ld_status;
  logic [CNT_W-1:0]  ld_count;
  logic [CNT_W-1:0]  ld_removed;

  // RAM port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic    out_free, accept, empty, full;
  action_e act;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign act        = action_e'(action_i);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CNT_W'(DEPTH));

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    count_d    = count_q;
    key_d      = key_q;
    rd_k_d     = rd_k_q;
    wr_n_d     = wr_n_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    out_load   = 1'b0;
    ld_popped  = '0;
    ld_status  = ST_OK;
    ld_count   = count_q;
    ld_removed = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = ST_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_dec(front_q);
                ram_wdata = DATA_W'(value_i);
                front_d   = slot_dec(front_q);
                count_d   = count_q + CNT_W'(1);
                ld_count  = count_q + CNT_W'(1);
              end
            end
            ACT_PUSH_BACK: begin
              out_load = 1'b1;
              if (full) begin
                ld_status = ST_OVER;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot(front_q, count_q);
                ram_wdata = DATA_W'(value_i);
                count_d   = count_q + CNT_W'(1);
                ld_count  = count_q + CNT_W'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = ST_UNDER;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                front_d   = slot(front_q, CNT_W'(1));
                count_d   = count_q - CNT_W'(1);
                state_d   = S_POP;
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                out_load  = 1'b1;
                ld_status = ST_UNDER;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot(front_q, count_q - CNT_W'(1));
                count_d   = count_q - CNT_W'(1);
                state_d   = S_POP;
              end
            end
            ACT_REMOVE: begin
              if (empty) begin
                out_load = 1'b1;
              end else begin
                // start the walk: read offset 0 now
                key_d     = DATA_W'(value_i);
                ram_re    = 1'b1;
                ram_raddr = front_q;
                rd_k_d    = CNT_W'(1);
                wr_n_d    = '0;
                pend_d    = 1'b1;
                state_d   = S_RM;
              end
            end
            default: begin
              // unused codes: no-op result
              out_load = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        // count, and front for a front pop, were already updated at accept
        if (out_free) begin
          out_load  = 1'b1;
          ld_popped = ram_rdata;
          state_d   = S_IDLE;
        end
      end

      S_RM: begin
        if (pend_q) begin
          // kept entries slide towards the front; the write slot was read earlier
          if (ram_rdata != key_q) begin
            ram_we    = 1'b1;
            ram_waddr = slot(front_q, wr_n_q);
            ram_wdata = ram_rdata;
            wr_n_d    = wr_n_q + CNT_W'(1);
          end
          if (rd_k_q < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = slot(front_q, rd_k_q);
            rd_k_d    = rd_k_q + CNT_W'(1);
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          ld_count   = wr_n_q;
          ld_removed = count_q - wr_n_q;
          count_d    = wr_n_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rd_k_q      <= '0;
      wr_n_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      rd_k_q  <= rd_k_d;
      wr_n_q  <= wr_n_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_load) begin
      popped_q      <= POP_W'(ld_popped);
      status_q      <= ld_status;
      count_after_q <= CNT_OUT_W'(ld_count);
      removed_q     <= CNT_OUT_W'(ld_removed);
    end
  end

  bdq_ram #(
    .WORDS (DEPTH),
    .WIDTH (DATA_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign popped_word_o   = popped_q;
  assign status_o        = status_q;
  assign count_after_o   = count_after_q;
  assign removed_count_o = removed_q;

endmodule

// ===== hdl/bdq_chk.sv =====
// Checker on the deque unit's ports, bound to the top level.
`timescale 1ns / 1ps

module bdq_chk
  import bdq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [POP_W-1:0]     popped_word_o,
  input logic [ST_W-1:0]      status_o,
  input logic [CNT_OUT_W-1:0] count_after_o,
  input logic [CNT_OUT_W-1:0] removed_count_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // Underflow leaves nothing popped and nothing removed
  a_under_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDER |-> popped_word_o == '0 && removed_count_o == '0)
    else $error("underflow result carries data");

  // Overflow only happens with the store full
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVER |-> count_after_o == CNT_OUT_W'(DEPTH))
    else $error("overflow reported below capacity");

  // A transaction that removed entries popped nothing and was not an error
  a_remove_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != '0 |-> status_o == ST_OK && popped_word_o == '0)
    else $error("removal result mixed with pop or error");

endmodule

bind bounded_deque_with_value_removal_unit bdq_chk u_bdq_chk (.*);
